@@ rtl/positional_list_store_macros.svh @@
// Assertion macros for the positional list store checker.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/plst_pkg.sv @@
// Shared types and constants for the positional list store.
// Used by the controller, the datapath, the RAM, the top level and the checker.
`default_nettype none

package plst_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int ACTION_W     = 2;
  localparam int POS_W        = 7;
  localparam int PAYLOAD_IO_W = 32;
  localparam int COUNT_IO_W   = 7;
  localparam int STATUS_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SWAP   = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_WR,
    S_RM_RD,
    S_RM_CAP,
    S_RM_SH_RD,
    S_RM_SH_WR,
    S_SW_RDA,
    S_SW_RDB,
    S_SW_WRA,
    S_SW_WRB,
    S_RD_RD,
    S_RD_CAP
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_COUNT,
    IDX_LOAD_SLOT,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    RS_IDX_DN,
    RS_IDX_UP,
    RS_SLOT_A,
    RS_SLOT_B
  } rd_sel_e;

  typedef enum logic [1:0] {
    WA_IDX,
    WA_SLOT_A,
    WA_SLOT_B
  } wa_sel_e;

  typedef enum logic [1:0] {
    WD_WORD,
    WD_RDATA,
    WD_TMP
  } wd_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    idx_op_e idx_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wa_sel_e wa_sel;
    wd_sel_e wd_sel;
    logic    save_tmp;
    logic    cap_result;
    cnt_op_e cnt_op;
    logic    finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    err;
    logic    idx_at_slot;
    logic    idx_last;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/positional_list_store.sv @@
// Top level of the positional list store: controller plus datapath.
// Depends on plst_pkg, plst_ctrl, plst_dpath and plst_ram.
//
// Usage: drive action_i, pos_a_i, pos_b_i and payload_in_i and raise start.
// The request is taken at a rising edge where start is high and busy is low.
// busy stays high until the request has finished. Its result appears for
// exactly one cycle with done_o high: payload_out_o, entry_count_o and
// status_o. The receiver cannot hold a result off; it must take it then.
// A rejected request, a read or a swap moves no entry. An insert moves the
// count - pos + 1 entries at and above pos up by one slot, and a remove
// moves the count - pos entries above pos down by one slot.
// The next request may be taken in the cycle that done_o is high.
// Each moved entry costs a read and a write, because the entries
// live in one RAM with one read port (registered data) and one write port.
// Reset empties the store at once; entry contents are not cleared.
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY     = plst_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = plst_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [plst_pkg::ACTION_W-1:0]     action_i,
  input  wire logic [plst_pkg::POS_W-1:0]        pos_a_i,
  input  wire logic [plst_pkg::POS_W-1:0]        pos_b_i,
  input  wire logic [plst_pkg::PAYLOAD_IO_W-1:0] payload_in_i,
  output logic                                   done_o,
  output logic      [plst_pkg::PAYLOAD_IO_W-1:0] payload_out_o,
  output logic      [plst_pkg::COUNT_IO_W-1:0]   entry_count_o,
  output logic      [plst_pkg::STATUS_W-1:0]     status_o
);

  plst_pkg::cmd_t  cmd;
  plst_pkg::stat_t stat;

  plst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  plst_dpath #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (action_i),
    .pos_a_i      (pos_a_i),
    .pos_b_i      (pos_b_i),
    .payload_in_i (payload_in_i),
    .stat_o       (stat),
    .done_o       (done_o),
    .payload_out_o(payload_out_o),
    .entry_count_o(entry_count_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

@@ rtl/plst_ram.sv @@
// Generic single-clock RAM: one write port and one read port with registered read data.
// Depends on plst_pkg for its default sizes.
`default_nettype none

module plst_ram #(
  parameter int WIDTH = plst_pkg::PAYLOAD_BITS_DEF,
  parameter int DEPTH = plst_pkg::CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/plst_ctrl.sv @@
// Controller state machine of the positional list store.
// Sequences reads, writes and shifts in the datapath; depends on plst_pkg.
`default_nettype none

module plst_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire plst_pkg::stat_t stat_i,
  output logic                 busy_o,
  output plst_pkg::cmd_t       cmd_o
);

  plst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plst_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plst_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = plst_pkg::S_DECODE;
        end
      end
      plst_pkg::S_DECODE: begin
        if (stat_i.err) begin
          state_d = plst_pkg::S_IDLE;
        end else begin
          unique case (stat_i.action)
            plst_pkg::ACT_INSERT: state_d = plst_pkg::S_INS_RD;
            plst_pkg::ACT_REMOVE: state_d = plst_pkg::S_RM_RD;
            plst_pkg::ACT_SWAP:   state_d = plst_pkg::S_SW_RDA;
            plst_pkg::ACT_READ:   state_d = plst_pkg::S_RD_RD;
            default:              state_d = plst_pkg::S_IDLE;
          endcase
        end
      end
      plst_pkg::S_INS_RD: begin
        state_d = stat_i.idx_at_slot ? plst_pkg::S_IDLE : plst_pkg::S_INS_WR;
      end
      plst_pkg::S_INS_WR:   state_d = plst_pkg::S_INS_RD;
      plst_pkg::S_RM_RD:    state_d = plst_pkg::S_RM_CAP;
      plst_pkg::S_RM_CAP:   state_d = plst_pkg::S_RM_SH_RD;
      plst_pkg::S_RM_SH_RD: begin
        state_d = stat_i.idx_last ? plst_pkg::S_IDLE : plst_pkg::S_RM_SH_WR;
      end
      plst_pkg::S_RM_SH_WR: state_d = plst_pkg::S_RM_SH_RD;
      plst_pkg::S_SW_RDA:   state_d = plst_pkg::S_SW_RDB;
      plst_pkg::S_SW_RDB:   state_d = plst_pkg::S_SW_WRA;
      plst_pkg::S_SW_WRA:   state_d = plst_pkg::S_SW_WRB;
      plst_pkg::S_SW_WRB:   state_d = plst_pkg::S_IDLE;
      plst_pkg::S_RD_RD:    state_d = plst_pkg::S_RD_CAP;
      plst_pkg::S_RD_CAP:   state_d = plst_pkg::S_IDLE;
      default:              state_d = plst_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o            = '0;
    cmd_o.idx_op     = plst_pkg::IDX_HOLD;
    cmd_o.rd_sel     = plst_pkg::RS_SLOT_A;
    cmd_o.wa_sel     = plst_pkg::WA_IDX;
    cmd_o.wd_sel     = plst_pkg::WD_RDATA;
    cmd_o.cnt_op     = plst_pkg::CNT_HOLD;
    busy_o           = (state_q != plst_pkg::S_IDLE);
    unique case (state_q)
      plst_pkg::S_IDLE: begin
        cmd_o.load = start_i;
      end
      plst_pkg::S_DECODE: begin
        if (stat_i.err) begin
          cmd_o.finish = 1'b1;
        end else if (stat_i.action == plst_pkg::ACT_INSERT) begin
          cmd_o.idx_op = plst_pkg::IDX_LOAD_COUNT;
        end else if (stat_i.action == plst_pkg::ACT_REMOVE) begin
          cmd_o.idx_op = plst_pkg::IDX_LOAD_SLOT;
        end
      end
      plst_pkg::S_INS_RD: begin
        if (stat_i.idx_at_slot) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wa_sel = plst_pkg::WA_SLOT_A;
          cmd_o.wd_sel = plst_pkg::WD_WORD;
          cmd_o.cnt_op = plst_pkg::CNT_INC;
          cmd_o.finish = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = plst_pkg::RS_IDX_DN;
        end
      end
      plst_pkg::S_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.idx_op = plst_pkg::IDX_DEC;
      end
      plst_pkg::S_RM_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      plst_pkg::S_RM_CAP: begin
        cmd_o.cap_result = 1'b1;
      end
      plst_pkg::S_RM_SH_RD: begin
        if (stat_i.idx_last) begin
          cmd_o.cnt_op = plst_pkg::CNT_DEC;
          cmd_o.finish = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = plst_pkg::RS_IDX_UP;
        end
      end
      plst_pkg::S_RM_SH_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.idx_op = plst_pkg::IDX_INC;
      end
      plst_pkg::S_SW_RDA: begin
        cmd_o.rd_en = 1'b1;
      end
      plst_pkg::S_SW_RDB: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = plst_pkg::RS_SLOT_B;
        cmd_o.save_tmp = 1'b1;
      end
      plst_pkg::S_SW_WRA: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = plst_pkg::WA_SLOT_A;
      end
      plst_pkg::S_SW_WRB: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = plst_pkg::WA_SLOT_B;
        cmd_o.wd_sel = plst_pkg::WD_TMP;
        cmd_o.finish = 1'b1;
      end
      plst_pkg::S_RD_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      plst_pkg::S_RD_CAP: begin
        cmd_o.cap_result = 1'b1;
        cmd_o.finish     = 1'b1;
      end
      default: begin
        cmd_o.finish = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/plst_dpath.sv @@
// Datapath of the positional list store: request registers, count, shift index,
// range checks, entry RAM and result registers. Depends on plst_pkg and plst_ram.
`default_nettype none

module plst_dpath #(
  parameter int CAPACITY     = plst_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = plst_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire plst_pkg::cmd_t                    cmd_i,
  input  wire logic [plst_pkg::ACTION_W-1:0]     action_i,
  input  wire logic [plst_pkg::POS_W-1:0]        pos_a_i,
  input  wire logic [plst_pkg::POS_W-1:0]        pos_b_i,
  input  wire logic [plst_pkg::PAYLOAD_IO_W-1:0] payload_in_i,
  output plst_pkg::stat_t                        stat_o,
  output logic                                   done_o,
  output logic      [plst_pkg::PAYLOAD_IO_W-1:0] payload_out_o,
  output logic      [plst_pkg::COUNT_IO_W-1:0]   entry_count_o,
  output logic      [plst_pkg::STATUS_W-1:0]     status_o
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = (CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W;
  localparam int PXW = (PAYLOAD_BITS > plst_pkg::PAYLOAD_IO_W) ?
                       PAYLOAD_BITS : plst_pkg::PAYLOAD_IO_W;

  plst_pkg::action_e                 action_q;
  logic [plst_pkg::POS_W-1:0]        pa_q, pb_q;
  logic [PAYLOAD_BITS-1:0]           word_q, word_d;
  logic [AW-1:0]                     idx_q, idx_d;
  logic [CW-1:0]                     count_q, count_d;
  logic [PAYLOAD_BITS-1:0]           tmp_q;
  logic [plst_pkg::PAYLOAD_IO_W-1:0] result_q;
  plst_pkg::status_e                 status_q, status_d;
  logic                              done_q;

  logic [PXW-1:0]          pin_x, rdata_x;
  logic [PAYLOAD_BITS-1:0] rdata;
  logic [XW-1:0]           count_x, slot_a_x, slot_b_x, idx_x;
  logic                    full, a_held, b_held, ins_ok, err_full, err_range;
  logic [AW-1:0]           raddr, waddr;
  logic [PAYLOAD_BITS-1:0] wdata;

  assign pin_x   = PXW'(payload_in_i);
  assign word_d  = pin_x[PAYLOAD_BITS-1:0];
  assign rdata_x = PXW'(rdata);

  assign count_x  = XW'(count_q);
  assign idx_x    = XW'(idx_q);
  assign slot_a_x = XW'(pa_q) - XW'(1);
  assign slot_b_x = XW'(pb_q) - XW'(1);

  assign full   = (count_x >= XW'(CAPACITY));
  assign a_held = (pa_q != '0) && (slot_a_x < count_x);
  assign b_held = (pb_q != '0) && (slot_b_x < count_x);
  assign ins_ok = (pa_q != '0) && (slot_a_x <= count_x);

  always_comb begin
    err_full  = 1'b0;
    err_range = 1'b0;
    unique case (action_q) inside
      plst_pkg::ACT_INSERT: begin
        err_full  = full;
        err_range = !full && !ins_ok;
      end
      plst_pkg::ACT_REMOVE, plst_pkg::ACT_READ: begin
        err_range = !a_held;
      end
      plst_pkg::ACT_SWAP: begin
        err_range = !(a_held && b_held);
      end
      default: begin
        err_range = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (err_full) begin
      status_d = plst_pkg::ST_FULL;
    end else if (err_range) begin
      status_d = plst_pkg::ST_RANGE;
    end else begin
      status_d = plst_pkg::ST_OK;
    end
  end

  assign stat_o.action      = action_q;
  assign stat_o.err         = err_full || err_range;
  assign stat_o.idx_at_slot = (idx_x == slot_a_x);
  assign stat_o.idx_last    = ((idx_x + XW'(1)) >= count_x);

  // Shift index and entry count.
  always_comb begin
    case (cmd_i.idx_op)
      plst_pkg::IDX_LOAD_COUNT: idx_d = count_x[AW-1:0];
      plst_pkg::IDX_LOAD_SLOT:  idx_d = slot_a_x[AW-1:0];
      plst_pkg::IDX_INC:        idx_d = idx_q + AW'(1);
      plst_pkg::IDX_DEC:        idx_d = idx_q - AW'(1);
      default:                  idx_d = idx_q;
    endcase
    case (cmd_i.cnt_op)
      plst_pkg::CNT_INC: count_d = count_q + CW'(1);
      plst_pkg::CNT_DEC: count_d = count_q - CW'(1);
      default:           count_d = count_q;
    endcase
  end

  // RAM address and data selection.
  always_comb begin
    case (cmd_i.rd_sel)
      plst_pkg::RS_IDX_DN: raddr = idx_q - AW'(1);
      plst_pkg::RS_IDX_UP: raddr = idx_q + AW'(1);
      plst_pkg::RS_SLOT_B: raddr = slot_b_x[AW-1:0];
      default:             raddr = slot_a_x[AW-1:0];
    endcase
    case (cmd_i.wa_sel)
      plst_pkg::WA_SLOT_A: waddr = slot_a_x[AW-1:0];
      plst_pkg::WA_SLOT_B: waddr = slot_b_x[AW-1:0];
      default:             waddr = idx_q;
    endcase
    case (cmd_i.wd_sel)
      plst_pkg::WD_WORD: wdata = word_q;
      plst_pkg::WD_TMP:  wdata = tmp_q;
      default:           wdata = rdata;
    endcase
  end

  plst_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load) begin
      action_q <= plst_pkg::action_e'(action_i);
      pa_q     <= pos_a_i;
      pb_q     <= pos_b_i;
      word_q   <= word_d;
      result_q <= '0;
    end else if (cmd_i.cap_result) begin
      result_q <= rdata_x[plst_pkg::PAYLOAD_IO_W-1:0];
    end
    if (cmd_i.save_tmp) begin
      tmp_q <= rdata;
    end
    if (cmd_i.finish) begin
      status_q <= status_d;
    end
  end

  assign done_o        = done_q;
  assign payload_out_o = result_q;
  assign entry_count_o = count_x[plst_pkg::COUNT_IO_W-1:0];
  assign status_o      = status_q;

endmodule

`default_nettype wire

@@ rtl/plst_checker.sv @@
// Port-level assertions for the positional list store, bound to the top level.
// Depends on plst_pkg and positional_list_store_macros.svh.
`default_nettype none

`include "positional_list_store_macros.svh"

module plst_checker #(
  parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done_o,
  input wire logic [plst_pkg::PAYLOAD_IO_W-1:0] payload_out_o,
  input wire logic [plst_pkg::COUNT_IO_W-1:0]   entry_count_o,
  input wire logic [plst_pkg::STATUS_W-1:0]     status_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > plst_pkg::COUNT_IO_W) ? CW : plst_pkg::COUNT_IO_W;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
  localparam logic [plst_pkg::COUNT_IO_W-1:0] FULL_COUNT = CAP_X[plst_pkg::COUNT_IO_W-1:0];

  logic fail_done, full_done;

  assign fail_done = done_o && (status_o != plst_pkg::ST_OK);
  assign full_done = done_o && (status_o == plst_pkg::ST_FULL);

  // An accepted request keeps the block busy in the following cycle.
  `PLST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after a request")

  // A result is only shown once the block has gone idle, and never twice in a row.
  `PLST_ASSERT_NOW(a_done_idle, done_o, !busy, "result shown while busy")
  `PLST_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe held for two cycles")

  // A failed request returns a zero payload; a full store reports its capacity.
  `PLST_ASSERT_NOW(a_fail_zero, fail_done, payload_out_o == '0, "failed request returned data")
  `PLST_ASSERT_NOW(a_full_count, full_done, entry_count_o == FULL_COUNT, "full with wrong count")

endmodule

bind positional_list_store plst_checker #(.CAPACITY(CAPACITY)) u_plst_checker (.*);

`default_nettype wire

@@ sim/positional_list_store_checker.sv @@
`timescale 1ns / 1ps
// Checker for the positional list store: keeps a shadow copy of the list,
// predicts the reply to every accepted request and compares it with the
// reply that the block returns. Depends on plst_pkg.
module positional_list_store_checker
  import plst_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic [ACTION_W-1:0]     action_i,
  input  wire logic [POS_W-1:0]        pos_a_i,
  input  wire logic [POS_W-1:0]        pos_b_i,
  input  wire logic [PAYLOAD_IO_W-1:0] payload_in_i,
  input  wire logic                    done_o,
  input  wire logic [PAYLOAD_IO_W-1:0] payload_out_o,
  input  wire logic [COUNT_IO_W-1:0]   entry_count_o,
  input  wire logic [STATUS_W-1:0]     status_o,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct {
    logic [PAYLOAD_IO_W-1:0] word;
    logic [COUNT_IO_W-1:0]   count;
    status_e                 status;
  } reply_t;

  logic [PAYLOAD_IO_W-1:0] shadow_list [DEPTH];
  int                      shadow_len = 0;
  reply_t                  awaited_replies [$];
  int                      failures = 0;

  // Applies one request to the shadow list and returns the reply it should give.
  function automatic reply_t apply_request(action_e act, int pa, int pb,
                                           logic [PAYLOAD_IO_W-1:0] word);
    reply_t                  r;
    logic [PAYLOAD_IO_W-1:0] held_word;
    int                      i;
    r.word   = '0;
    r.status = ST_OK;
    case (act)
      ACT_INSERT: begin
        // A full list is reported before the position is looked at.
        if (shadow_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (pa < 1 || pa > shadow_len + 1) begin
          r.status = ST_RANGE;
        end else begin
          for (i = shadow_len; i > pa - 1; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[pa - 1] = word;
          shadow_len++;
        end
      end
      ACT_REMOVE: begin
        if (pa < 1 || pa > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          r.word = shadow_list[pa - 1];
          for (i = pa - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
        end
      end
      ACT_SWAP: begin
        if (pa < 1 || pa > shadow_len || pb < 1 || pb > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          held_word           = shadow_list[pa - 1];
          shadow_list[pa - 1] = shadow_list[pb - 1];
          shadow_list[pb - 1] = held_word;
        end
      end
      default: begin
        if (pa < 1 || pa > shadow_len) r.status = ST_RANGE;
        else r.word = shadow_list[pa - 1];
      end
    endcase
    r.count = shadow_len[COUNT_IO_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    reply_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      awaited_replies.delete();
    end else begin
      // Replies are taken before requests: a new request may be accepted in
      // the very cycle that the previous reply is presented.
      if (done_o) begin
        if (awaited_replies.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: reply with no request outstanding: word %h count %0d status %0d",
                     $realtime, payload_out_o, entry_count_o, status_o);
        end else begin
          want = awaited_replies.pop_front();
          if (payload_out_o !== want.word || entry_count_o !== want.count ||
              status_o !== want.status) begin
            failures++;
            if (failures <= 10)
              $display("%0t: expected %h count %0d status %0d, got %h count %0d status %0d",
                       $realtime, want.word, want.count, want.status,
                       payload_out_o, entry_count_o, status_o);
          end
        end
      end
      if (start && !busy)
        awaited_replies.push_back(apply_request(action_e'(action_i), int'(pos_a_i),
                                                int'(pos_b_i), payload_in_i));
    end
    pending_o    <= awaited_replies.size();
    fail_count_o <= failures;
  end

endmodule

@@ sim/positional_list_store_tb.sv @@
`timescale 1ns / 1ps
// Top of the positional list store testbench: clock, reset, request stimulus
// and the verdict. Depends on plst_pkg, positional_list_store and the checker.
module positional_list_store_tb;
  import plst_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int NUM_RANDOM  = 1000;
  localparam int CYCLE_LIMIT = 1000000;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    start        = 1'b0;
  logic [ACTION_W-1:0]     action_i     = ACT_READ;
  logic [POS_W-1:0]        pos_a_i      = '0;
  logic [POS_W-1:0]        pos_b_i      = '0;
  logic [PAYLOAD_IO_W-1:0] payload_in_i = '0;
  logic                    busy;
  logic                    done_o;
  logic [PAYLOAD_IO_W-1:0] payload_out_o;
  logic [COUNT_IO_W-1:0]   entry_count_o;
  logic [STATUS_W-1:0]     status_o;

  int fail_count;
  int pending_replies;
  int cycle_count = 0;
  int held_len    = 0;     // list length as the stimulus sees it, used to aim positions
  bit may_idle    = 1'b1;

  positional_list_store DUT (.*);

  positional_list_store_checker #(.DEPTH(DEPTH)) checker_i (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending_replies)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Presents one request, waits for the edge that accepts it and at times drops start for a gap before returning.
  task automatic send_request(action_e act, logic [POS_W-1:0] pa, logic [POS_W-1:0] pb,
                              logic [PAYLOAD_IO_W-1:0] word);
    start        <= 1'b1;
    action_i     <= act;
    pos_a_i      <= pa;
    pos_b_i      <= pb;
    payload_in_i <= word;
    do @(posedge clk_i); while (busy);
    case (act)
      ACT_INSERT: if (held_len < DEPTH && pa >= 1 && pa <= held_len + 1) held_len++;
      ACT_REMOVE: if (pa >= 1 && pa <= held_len) held_len--;
      default: ;
    endcase
    // Gaps of varying length land on different phases of the next request.
    if (may_idle && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic random_request(int insert_pct, int remove_pct);
    action_e                 act;
    logic [POS_W-1:0]        pa;
    logic [POS_W-1:0]        pb;
    logic [PAYLOAD_IO_W-1:0] word;
    int                      pick;
    pick = $urandom_range(99);
    if (pick < insert_pct) act = ACT_INSERT;
    else if (pick < insert_pct + remove_pct) act = ACT_REMOVE;
    else act = $urandom_range(1) ? ACT_SWAP : ACT_READ;

    if ($urandom_range(99) < 10 || (held_len == 0 && act != ACT_INSERT))
      pa = POS_W'($urandom_range(127));
    else if (act == ACT_INSERT)
      pa = POS_W'($urandom_range(1, held_len + 1));
    else
      pa = POS_W'($urandom_range(1, held_len));

    pick = $urandom_range(9);
    if (pick == 0) pb = pa;
    else if (pick == 1) pb = (pa < held_len) ? pa + POS_W'(1) : pa - POS_W'(1);
    else if (pick == 2 || held_len == 0) pb = POS_W'($urandom_range(127));
    else pb = POS_W'($urandom_range(1, held_len));

    pick = $urandom_range(15);
    if (pick == 0) word = '0;
    else if (pick == 1) word = '1;
    else word = $urandom;
    send_request(act, pa, pb, word);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Requests on an empty list, then a short list built and reshuffled.
    send_request(ACT_READ,   1,   1, '0);
    send_request(ACT_REMOVE, 1,   1, '0);
    send_request(ACT_SWAP,   1,   1, '0);
    send_request(ACT_INSERT, 0,   0, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 2,   1, 32'h1234_5678);
    send_request(ACT_INSERT, 1,   1, 32'h0000_0000);
    send_request(ACT_INSERT, 1,   1, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 3,   1, 32'hA5A5_A5A5);
    send_request(ACT_INSERT, 2,   1, 32'h5A5A_5A5A);
    send_request(ACT_SWAP,   1,   2, '0);
    send_request(ACT_SWAP,   3,   2, '0);
    send_request(ACT_SWAP,   2,   2, '0);
    send_request(ACT_SWAP,   1,   4, '0);
    send_request(ACT_SWAP,   1,   5, '0);
    send_request(ACT_SWAP,   127, 1, '0);
    send_request(ACT_READ,   4,   0, '0);
    send_request(ACT_READ,   5,   0, '0);
    send_request(ACT_READ,   127, 127, '0);
    send_request(ACT_REMOVE, 4,   0, '0);
    send_request(ACT_REMOVE, 1,   0, '0);
    send_request(ACT_REMOVE, 2,   0, '0);
    send_request(ACT_INSERT, 127, 0, 32'h8000_0001);
    send_request(ACT_REMOVE, 1,   0, '0);

    // Alternate mixed, filling and draining stretches so that the list
    // reaches both full and empty several times.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      may_idle = !(i >= 400 && i < 600);
      case ((i / 150) % 3)
        0:       random_request(40, 25);
        1:       random_request(75, 10);
        default: random_request(10, 70);
      endcase
    end

    start <= 1'b0;
    @(posedge clk_i);
    wait (pending_replies == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ positional_list_store.f @@
+incdir+rtl
rtl/plst_pkg.sv
rtl/plst_ram.sv
rtl/plst_ctrl.sv
rtl/plst_dpath.sv
rtl/positional_list_store.sv
rtl/plst_checker.sv
sim/positional_list_store_checker.sv
sim/positional_list_store_tb.sv
